// ===== rtl/core/rdd_pkg.sv =====
// Package: shared types and constants for the reversible deque drain block.
`timescale 1ns / 1ps
`default_nettype none

package rdd_pkg;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PTR_W  = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		REQ_PUSH    = 2'd0,
		REQ_REVERSE = 2'd1,
		REQ_DELETE  = 2'd2,
		REQ_EMIT    = 2'd3
	} req_kind_t;

	typedef struct packed {
		logic [1:0]               req_type;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value_res;
		logic                     is_last;
		logic                     is_error;
		logic                     is_empty;
	} res_t;

	// Port group from the controller to the element RAM.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// Flags of a result, which appears in the cycle after its drain read or emit.
	typedef struct packed {
		logic strobe;
		logic use_data;
		logic last;
		logic err;
		logic empty;
	} res_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/rdd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rdd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rdd_ctrl.sv =====
// Controller: head/tail pointers, reverse and error flags, drain sequencer.
`timescale 1ns / 1ps
`default_nettype none

module rdd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire rdd_pkg::req_t     req,
	output logic                   busy,
	output rdd_pkg::ram_req_t      ram_req,
	output rdd_pkg::res_ctl_t      res_ctl
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t                    state_q;
	logic [rdd_pkg::PTR_W-1:0] head_q;
	logic [rdd_pkg::PTR_W-1:0] tail_q;
	logic                      rev_q;
	logic                      err_q;
	logic [rdd_pkg::PTR_W-1:0] cursor_q;
	logic [rdd_pkg::PTR_W-1:0] remain_q;
	logic                      drain_rev_q;
	rdd_pkg::res_ctl_t         res_s1;
	rdd_pkg::res_ctl_t         res_d;

	logic accept;
	logic is_empty;
	logic is_full;
	logic drain_rd;
	rdd_pkg::req_kind_t kind;

	assign busy     = (state_q == ST_DRAIN);
	assign accept   = start && !busy;
	assign kind     = rdd_pkg::req_kind_t'(req.req_type);
	assign is_empty = (head_q >= tail_q);
	assign is_full  = (tail_q == rdd_pkg::PTR_W'(rdd_pkg::DEPTH));
	assign drain_rd = (state_q == ST_DRAIN);

	always_comb begin
		ram_req.we    = accept && (kind == rdd_pkg::REQ_PUSH) && !err_q && !is_full;
		ram_req.waddr = tail_q[rdd_pkg::ADDR_W-1:0];
		ram_req.wdata = req.value;
		ram_req.re    = drain_rd;
		ram_req.raddr = cursor_q[rdd_pkg::ADDR_W-1:0];
	end

	// Flags of the result that leaves in the next cycle.
	always_comb begin
		res_d = '0;
		if (drain_rd) begin
			res_d.strobe   = 1'b1;
			res_d.use_data = 1'b1;
			res_d.last     = (remain_q == rdd_pkg::PTR_W'(1));
		end else if (accept && (kind == rdd_pkg::REQ_EMIT) && (err_q || is_empty)) begin
			res_d.strobe = 1'b1;
			res_d.last   = 1'b1;
			res_d.err    = err_q;
			res_d.empty  = !err_q;
		end
	end

	assign res_ctl = res_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			rev_q       <= 1'b0;
			err_q       <= 1'b0;
			cursor_q    <= '0;
			remain_q    <= '0;
			drain_rev_q <= 1'b0;
			res_s1      <= '0;
		end else begin
			res_s1 <= res_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (kind)
							rdd_pkg::REQ_PUSH: begin
								if (!err_q) begin
									if (is_full) begin
										err_q <= 1'b1;
									end else begin
										tail_q <= tail_q + 1'b1;
									end
								end
							end
							rdd_pkg::REQ_REVERSE: begin
								if (!err_q) begin
									rev_q <= !rev_q;
								end
							end
							rdd_pkg::REQ_DELETE: begin
								if (!err_q) begin
									if (is_empty) begin
										err_q <= 1'b1;
									end else if (rev_q) begin
										tail_q <= tail_q - 1'b1;
									end else begin
										head_q <= head_q + 1'b1;
									end
								end
							end
							rdd_pkg::REQ_EMIT: begin
								// Snapshot the run, then clear for the next one.
								if (!err_q && !is_empty) begin
									state_q     <= ST_DRAIN;
									cursor_q    <= rev_q ? (tail_q - 1'b1) : head_q;
									remain_q    <= tail_q - head_q;
									drain_rev_q <= rev_q;
								end
								head_q <= '0;
								tail_q <= '0;
								rev_q  <= 1'b0;
								err_q  <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_DRAIN: begin
					cursor_q <= drain_rev_q ? (cursor_q - 1'b1) : (cursor_q + 1'b1);
					remain_q <= remain_q - 1'b1;
					if (remain_q == rdd_pkg::PTR_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_write_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (state_q == ST_IDLE))
		else $error("element write during drain");

	a_drain_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (remain_q != '0))
		else $error("drain with nothing left");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DRAIN) && (remain_q == rdd_pkg::PTR_W'(1)))
		|=> (res_s1.strobe && res_s1.last && (state_q == ST_IDLE)))
		else $error("drain run did not end with a last result");

	a_ptr_order: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q <= tail_q) && (tail_q <= rdd_pkg::PTR_W'(rdd_pkg::DEPTH)))
		else $error("pointer out of order");

endmodule

`default_nettype wire

// ===== rtl/core/reversible_deque_drain.sv =====
// Top level: deque with lazy reverse, element store in RAM, drain on emit.
//
// Push, reverse and delete commands may be given in every cycle while busy
// is low. An emit over n stored elements holds busy high while it makes one
// RAM read per cycle, and its n results follow one per cycle, each in the
// cycle after its read, the last marked by is_last. An emit
// after an error or on an empty buffer gives its single result in the next
// cycle and leaves busy low. Results are strobed for one cycle and cannot be
// held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module reversible_deque_drain (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire rdd_pkg::req_t req,
	output logic               busy,
	output logic               strobe,
	output rdd_pkg::res_t      res
);

	rdd_pkg::ram_req_t         ram_req;
	rdd_pkg::res_ctl_t         res_ctl;
	logic [rdd_pkg::DATA_W-1:0] rdata;

	rdd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.ram_req (ram_req),
		.res_ctl (res_ctl)
	);

	rdd_ram #(
		.WIDTH (rdd_pkg::DATA_W),
		.DEPTH (rdd_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rdata)
	);

	always_comb begin
		strobe        = res_ctl.strobe;
		res.value_res = res_ctl.use_data ? $signed(rdata) : '0;
		res.is_last   = res_ctl.last;
		res.is_error  = res_ctl.err;
		res.is_empty  = res_ctl.empty;
	end

endmodule

`default_nettype wire

// ===== bench/tb_reversible_deque_drain.sv =====
// Testbench for the reversible deque drain block: directed and random command streams.
`timescale 1ns / 1ps

module tb_reversible_deque_drain;

	localparam int QUIET_LIMIT = 1000;
	localparam int MAX_GAP     = 20;

	logic          clk    = 1'b0;
	logic          arst_n = 1'b0;
	logic          start  = 1'b0;
	rdd_pkg::req_t req    = '0;
	logic          busy;
	logic          strobe;
	rdd_pkg::res_t res;

	reversible_deque_drain dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.strobe (strobe),
		.res    (res)
	);

	// shadow deque
	logic [rdd_pkg::DATA_W-1:0] shadow_store [rdd_pkg::DEPTH];
	int unsigned                shadow_head;
	int unsigned                shadow_tail;
	bit                         shadow_rev;
	bit                         shadow_err;

	rdd_pkg::res_t expected_drain[$];
	rdd_pkg::res_t drain_front;
	int   mismatch_count = 0;
	int   quiet_cycles = 0;
	int   items_sent = 0;
	int   idle_pct = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void push_drain(logic [rdd_pkg::DATA_W-1:0] v, bit last, bit err,
		bit empty);
		rdd_pkg::res_t e;
		e.value_res = v;
		e.is_last   = last;
		e.is_error  = err;
		e.is_empty  = empty;
		expected_drain.push_back(e);
	endfunction

	// Update the shadow deque with one accepted transaction and queue its results.
	function automatic void deque_apply(rdd_pkg::req_t r);
		int unsigned count;
		int unsigned pos;
		count = 0;
		pos = 0;
		case (rdd_pkg::req_kind_t'(r.req_type))
			rdd_pkg::REQ_EMIT: begin
				if (shadow_err) begin
					push_drain('0, 1'b1, 1'b1, 1'b0);
				end else if (shadow_head >= shadow_tail) begin
					push_drain('0, 1'b1, 1'b0, 1'b1);
				end else begin
					count = shadow_tail - shadow_head;
					for (int unsigned k = 0; k < count; k++) begin
						pos = shadow_rev ? (shadow_tail - 1 - k) : (shadow_head + k);
						push_drain(shadow_store[pos], (k + 1 == count), 1'b0, 1'b0);
					end
				end
				shadow_head = 0;
				shadow_tail = 0;
				shadow_rev  = 1'b0;
				shadow_err  = 1'b0;
			end
			rdd_pkg::REQ_PUSH: begin
				if (!shadow_err) begin
					if (shadow_tail < rdd_pkg::DEPTH) begin
						shadow_store[shadow_tail] = r.value;
						shadow_tail++;
					end else begin
						shadow_err = 1'b1;
					end
				end
			end
			rdd_pkg::REQ_REVERSE: begin
				if (!shadow_err)
					shadow_rev = !shadow_rev;
			end
			default: begin
				if (!shadow_err) begin
					if (shadow_head >= shadow_tail)
						shadow_err = 1'b1;
					else if (shadow_rev)
						shadow_tail--;
					else
						shadow_head++;
				end
			end
		endcase
	endfunction

	// Result checking, prediction on acceptance and the watchdog, in one ordered process.
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe) begin
				if (expected_drain.size() == 0) begin
					$error("unexpected result: value_res=%0d is_last=%0b is_error=%0b is_empty=%0b",
						res.value_res, res.is_last, res.is_error, res.is_empty);
					mismatch_count++;
				end else begin
					drain_front = expected_drain.pop_front();
					if (res.value_res !== drain_front.value_res) begin
						$error("value_res: expected %0d, got %0d",
							drain_front.value_res, res.value_res);
						mismatch_count++;
					end
					if (res.is_last !== drain_front.is_last) begin
						$error("is_last: expected %0b, got %0b", drain_front.is_last, res.is_last);
						mismatch_count++;
					end
					if (res.is_error !== drain_front.is_error) begin
						$error("is_error: expected %0b, got %0b",
							drain_front.is_error, res.is_error);
						mismatch_count++;
					end
					if (res.is_empty !== drain_front.is_empty) begin
						$error("is_empty: expected %0b, got %0b",
							drain_front.is_empty, res.is_empty);
						mismatch_count++;
					end
				end
			end
			if (start && !busy)
				deque_apply(req);
			if ((start && !busy) || strobe)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Send one transaction, with random idle cycles ahead of it.
	task automatic send_req(input rdd_pkg::req_kind_t kind,
		input logic [rdd_pkg::DATA_W-1:0] val);
		rdd_pkg::req_t nz;
		rdd_pkg::req_t r;
		int            gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
			@(negedge clk);
			nz.req_type = 2'($urandom);
			nz.value    = $urandom;
			start <= 1'b0;
			req   <= nz;
			gap++;
		end
		r.req_type = kind;
		r.value    = val;
		@(negedge clk);
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic send_cmd(input rdd_pkg::req_kind_t kind);
		send_req(kind, $urandom);
	endtask

	// Hold the sender off until every queued result has come back.
	task automatic wait_drain();
		@(negedge clk);
		start <= 1'b0;
		while (expected_drain.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_extremes();
		send_req(rdd_pkg::REQ_PUSH, 32'h8000_0000);
		send_req(rdd_pkg::REQ_PUSH, 32'h7fff_ffff);
		send_req(rdd_pkg::REQ_PUSH, 32'h0000_0000);
		send_req(rdd_pkg::REQ_PUSH, 32'hffff_ffff);
		send_cmd(rdd_pkg::REQ_EMIT);
		send_req(rdd_pkg::REQ_PUSH, 32'haaaa_aaaa);
		send_req(rdd_pkg::REQ_PUSH, 32'h5555_5555);
		send_req(rdd_pkg::REQ_PUSH, 32'h0000_0001);
		send_cmd(rdd_pkg::REQ_REVERSE);
		send_cmd(rdd_pkg::REQ_EMIT);
	endtask

	task automatic test_empty_and_error();
		send_cmd(rdd_pkg::REQ_EMIT);
		send_cmd(rdd_pkg::REQ_REVERSE);
		send_cmd(rdd_pkg::REQ_EMIT);
		// delete on empty latches the error; later push, reverse and delete commands are ignored until the emit
		send_cmd(rdd_pkg::REQ_DELETE);
		send_req(rdd_pkg::REQ_PUSH, 32'h1234_5678);
		send_cmd(rdd_pkg::REQ_REVERSE);
		send_cmd(rdd_pkg::REQ_DELETE);
		send_cmd(rdd_pkg::REQ_EMIT);
		send_cmd(rdd_pkg::REQ_EMIT);
	endtask

	task automatic test_reverse_delete();
		send_req(rdd_pkg::REQ_PUSH, 32'd1);
		send_req(rdd_pkg::REQ_PUSH, 32'd2);
		send_req(rdd_pkg::REQ_PUSH, 32'd3);
		send_req(rdd_pkg::REQ_PUSH, 32'd4);
		send_cmd(rdd_pkg::REQ_DELETE);
		send_cmd(rdd_pkg::REQ_REVERSE);
		send_cmd(rdd_pkg::REQ_DELETE);
		send_cmd(rdd_pkg::REQ_REVERSE);
		send_cmd(rdd_pkg::REQ_REVERSE);
		send_cmd(rdd_pkg::REQ_EMIT);
		// delete down to empty, then emit
		send_req(rdd_pkg::REQ_PUSH, 32'd9);
		send_cmd(rdd_pkg::REQ_DELETE);
		send_cmd(rdd_pkg::REQ_EMIT);
	endtask

	task automatic test_overflow();
		for (int i = 0; i < rdd_pkg::DEPTH; i++)
			send_req(rdd_pkg::REQ_PUSH, $urandom);
		send_req(rdd_pkg::REQ_PUSH, $urandom);
		send_cmd(rdd_pkg::REQ_EMIT);
		// a slot freed at the head is not reused before the next emit
		for (int i = 0; i < rdd_pkg::DEPTH; i++)
			send_req(rdd_pkg::REQ_PUSH, $urandom);
		send_cmd(rdd_pkg::REQ_DELETE);
		send_req(rdd_pkg::REQ_PUSH, $urandom);
		send_cmd(rdd_pkg::REQ_EMIT);
		// full buffer drained in reverse
		for (int i = 0; i < rdd_pkg::DEPTH; i++)
			send_req(rdd_pkg::REQ_PUSH, $urandom);
		send_cmd(rdd_pkg::REQ_REVERSE);
		send_cmd(rdd_pkg::REQ_EMIT);
	endtask

	// Random sessions, each closed by an emit so the next starts from a clear deque.
	task automatic test_random(input int target);
		int stop_at;
		int n;
		int live;
		int pushed;
		int pick;
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			live = 0;
			pushed = 0;
			if ($urandom_range(9) < 7) begin
				n = ($urandom_range(11) == 0) ? rdd_pkg::DEPTH + int'($urandom_range(2))
					: int'($urandom_range(12));
				for (int i = 0; i < n; i++) begin
					pick = int'($urandom_range(9));
					if (n > rdd_pkg::DEPTH && pick > 0)
						pick = 0;
					if (pick < 6 || (pick >= 8 && live == 0)) begin
						send_req(rdd_pkg::REQ_PUSH, $urandom);
						if (pushed < rdd_pkg::DEPTH)
							live++;
						pushed++;
					end else if (pick < 8) begin
						send_cmd(rdd_pkg::REQ_REVERSE);
					end else begin
						send_cmd(rdd_pkg::REQ_DELETE);
						live--;
					end
				end
			end else begin
				n = int'($urandom_range(8));
				for (int i = 0; i < n; i++)
					send_cmd(rdd_pkg::req_kind_t'($urandom_range(3)));
			end
			send_cmd(rdd_pkg::REQ_EMIT);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		idle_pct = 33;
		test_extremes();
		test_empty_and_error();
		wait_drain();
		test_reverse_delete();
		test_overflow();
		wait_drain();

		idle_pct = 33;
		test_random(20);
		wait_drain();
		idle_pct = 61;
		test_random(20);
		wait_drain();
		idle_pct = 0;
		test_random(20);
		wait_drain();

		repeat (8) @(negedge clk);
		if (expected_drain.size() != 0) begin
			$error("%0d expected results never arrived", expected_drain.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
